// ===== design/pp_pkg.sv =====
package pp_pkg;

  // Vertex limit and the smallest polygon that has a perimeter
  localparam int MAX_VERTICES = 128;
  localparam int MIN_POINTS   = 3;

  // Field widths
  localparam int COORD_W = 16;
  localparam int CNT_W   = 8;
  localparam int SUM_W   = 24;
  localparam int DIFF_W  = 16;             // magnitude of a coordinate difference
  localparam int SQ_W    = 2 * DIFF_W;     // one squared difference
  localparam int RAD_W   = 34;             // radicand, padded to an even width
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int STEP_W  = 5;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);
  localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(MIN_POINTS);

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FEW   = 2'd1;
  localparam logic [1:0] ST_TRUNC = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // latch the incoming vertex
    logic take_first;  // vertex becomes first and previous
    logic set_ovf;     // vertex dropped at the limit
    logic diff_load;   // register |dx| and |dy|
    logic close;       // edge runs from previous back to first
    logic sq_load;     // register the squares
    logic root_start;  // start the square root unit
    logic acc;         // add the root to the sum
    logic advance;     // previous <= current, count up
    logic emit;        // load the result register and clear the polygon
  } pp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic cnt_zero;
    logic below_max;
    logic below_min;
    logic last;
    logic root_done;
    logic out_free;
  } pp_stat_t;

endpackage

// ===== design/pp_isqrt.sv =====
module pp_isqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [pp_pkg::RAD_W-1:0]    radicand,
  output logic                        done,
  output logic [pp_pkg::ROOT_W-1:0]   root
);

  logic [pp_pkg::RAD_W-1:0]  rad_r;
  logic [pp_pkg::REM_W-1:0]  rem_r;
  logic [pp_pkg::ROOT_W-1:0] root_r;
  logic [pp_pkg::STEP_W-1:0] step_r;

  logic [pp_pkg::REM_W-1:0] cand;
  logic [pp_pkg::REM_W-1:0] trial;
  logic                     fits;

  // One result bit a step: bring down two radicand bits, try (root << 2) | 1
  assign cand  = {rem_r[pp_pkg::REM_W-3:0], rad_r[pp_pkg::RAD_W-1 -: 2]};
  assign trial = {1'b0, root_r, 2'b01};
  assign fits  = (cand >= trial);

  // Hold the step count; zero means idle with a valid root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (start) begin
      step_r <= pp_pkg::STEP_W'(pp_pkg::ROOT_W);
    end else if (step_r != '0) begin
      step_r <= step_r - 1'b1;
    end
  end

  // Advance the remainder and root
  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (step_r != '0) begin
      rad_r  <= {rad_r[pp_pkg::RAD_W-3:0], 2'b00};
      rem_r  <= fits ? (cand - trial) : cand;
      root_r <= {root_r[pp_pkg::ROOT_W-2:0], fits};
    end
  end

  assign done = (step_r == '0);
  assign root = root_r;

endmodule

// ===== design/pp_dp.sv =====
module pp_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pp_pkg::pp_cmd_t                    cmd,
  output pp_pkg::pp_stat_t                   stat,
  input  logic signed [pp_pkg::COORD_W-1:0]  in_x_coord,
  input  logic signed [pp_pkg::COORD_W-1:0]  in_y_coord,
  input  logic                               in_last_vertex,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pp_pkg::SUM_W-1:0]           out_perimeter,
  output logic [1:0]                         out_status
);

  logic signed [pp_pkg::COORD_W-1:0] cur_x_r, cur_y_r;
  logic signed [pp_pkg::COORD_W-1:0] first_x_r, first_y_r;
  logic signed [pp_pkg::COORD_W-1:0] prev_x_r, prev_y_r;
  logic                              last_r;
  logic [pp_pkg::CNT_W-1:0]          cnt_r;
  logic [pp_pkg::SUM_W-1:0]          sum_r;
  logic                              ovf_r;
  logic [pp_pkg::DIFF_W-1:0]         ux_r, uy_r;
  logic [pp_pkg::SQ_W-1:0]           sqx_r, sqy_r;
  logic [pp_pkg::SUM_W-1:0]          perim_r;
  logic [1:0]                        status_r;
  logic                              out_valid_r;

  logic signed [pp_pkg::COORD_W-1:0] bx, by;
  logic signed [pp_pkg::COORD_W:0]   dx, dy;
  logic        [pp_pkg::COORD_W:0]   ndx, ndy;
  logic [pp_pkg::RAD_W-1:0]          radicand;
  logic                              root_done;
  logic [pp_pkg::ROOT_W-1:0]         root;
  logic [pp_pkg::SUM_W:0]            sum_wide;

  // Edge end point: the current vertex, or the first one for the closing edge
  assign bx  = cmd.close ? first_x_r : cur_x_r;
  assign by  = cmd.close ? first_y_r : cur_y_r;
  assign dx  = {bx[pp_pkg::COORD_W-1], bx} - {prev_x_r[pp_pkg::COORD_W-1], prev_x_r};
  assign dy  = {by[pp_pkg::COORD_W-1], by} - {prev_y_r[pp_pkg::COORD_W-1], prev_y_r};
  assign ndx = dx[pp_pkg::COORD_W] ? (~dx + 1'b1) : dx;
  assign ndy = dy[pp_pkg::COORD_W] ? (~dy + 1'b1) : dy;

  assign radicand = pp_pkg::RAD_W'(sqx_r) + pp_pkg::RAD_W'(sqy_r);
  assign sum_wide = {1'b0, sum_r} + (pp_pkg::SUM_W + 1)'(root);

  pp_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.root_start),
    .radicand (radicand),
    .done     (root_done),
    .root     (root)
  );

  // Capture the vertex and work the edge operands
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_x_r <= in_x_coord;
      cur_y_r <= in_y_coord;
      last_r  <= in_last_vertex;
    end
    if (cmd.take_first) begin
      first_x_r <= cur_x_r;
      first_y_r <= cur_y_r;
    end
    if (cmd.take_first || cmd.advance) begin
      prev_x_r <= cur_x_r;
      prev_y_r <= cur_y_r;
    end
    if (cmd.diff_load) begin
      ux_r <= ndx[pp_pkg::DIFF_W-1:0];
      uy_r <= ndy[pp_pkg::DIFF_W-1:0];
    end
    if (cmd.sq_load) begin
      sqx_r <= pp_pkg::SQ_W'(ux_r) * pp_pkg::SQ_W'(ux_r);
      sqy_r <= pp_pkg::SQ_W'(uy_r) * pp_pkg::SQ_W'(uy_r);
    end
  end

  // Polygon state: count, saturating sum, truncation flag
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      cnt_r <= '0;
      sum_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      if (cmd.take_first) begin
        cnt_r <= pp_pkg::CNT_W'(1);
      end else if (cmd.advance) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.acc) begin
        sum_r <= sum_wide[pp_pkg::SUM_W] ? '1 : sum_wide[pp_pkg::SUM_W-1:0];
      end
      if (cmd.set_ovf) begin
        ovf_r <= 1'b1;
      end
    end
  end

  // Result register: hold until the transfer completes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (stat.below_min) begin
        perim_r  <= '0;
        status_r <= pp_pkg::ST_FEW;
      end else begin
        perim_r  <= sum_r;
        status_r <= ovf_r ? pp_pkg::ST_TRUNC : pp_pkg::ST_OK;
      end
    end
  end

  always_comb begin
    stat.cnt_zero  = (cnt_r == '0);
    stat.below_max = (cnt_r < pp_pkg::MAX_CNT);
    stat.below_min = (cnt_r < pp_pkg::MIN_CNT);
    stat.last      = last_r;
    stat.root_done = root_done;
    stat.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid     = out_valid_r;
  assign out_perimeter = perim_r;
  assign out_status    = status_r;

endmodule

// ===== design/pp_ctrl.sv =====
module pp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pp_pkg::pp_stat_t stat,
  output pp_pkg::pp_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECIDE,
    S_SQUARE,
    S_ROOT_GO,
    S_ROOT_WAIT,
    S_ACCUM,
    S_CLOSE,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   close_r, close_nxt;
  logic   in_stall_r;

  // Sequence one vertex: first, drop or edge length; on the last, close and emit
  always_comb begin
    state_nxt = state_r;
    close_nxt = close_r;
    cmd       = '0;
    cmd.close = close_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall_r) begin
          cmd.capture = 1'b1;
          close_nxt   = 1'b0;
          state_nxt   = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (stat.cnt_zero) begin
          cmd.take_first = 1'b1;
          state_nxt      = stat.last ? S_CLOSE : S_IDLE;
        end else if (stat.below_max) begin
          cmd.diff_load = 1'b1;
          state_nxt     = S_SQUARE;
        end else begin
          cmd.set_ovf = 1'b1;
          state_nxt   = stat.last ? S_CLOSE : S_IDLE;
        end
      end
      S_SQUARE: begin
        cmd.sq_load = 1'b1;
        state_nxt   = S_ROOT_GO;
      end
      S_ROOT_GO: begin
        cmd.root_start = 1'b1;
        state_nxt      = S_ROOT_WAIT;
      end
      S_ROOT_WAIT: begin
        if (stat.root_done) begin
          state_nxt = S_ACCUM;
        end
      end
      S_ACCUM: begin
        cmd.acc     = 1'b1;
        cmd.advance = !close_r;
        if (close_r) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = stat.last ? S_CLOSE : S_IDLE;
        end
      end
      S_CLOSE: begin
        if (stat.below_min) begin
          state_nxt = S_EMIT;
        end else begin
          close_nxt     = 1'b1;
          cmd.close     = 1'b1;
          cmd.diff_load = 1'b1;
          state_nxt     = S_SQUARE;
        end
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state, the closing flag and the input stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      close_r    <= 1'b0;
      in_stall_r <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      close_r    <= close_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = in_stall_r;

endmodule

// ===== design/polygon_perimeter.sv =====
// Channel | Handshake           | Payload
// --------+---------------------+-------------------------------------------
// in      | in_valid / in_stall | in_x_coord, in_y_coord, in_last_vertex
// out     | out_valid/out_stall | out_perimeter, out_status
//
// A vertex that opens a polygon or is dropped at the limit is captured and
// then decided. Each edge runs transfer, difference, squares, root start,
// the 17 steps of the bit-serial square root unit and the check that sees
// it finish, accumulate. The last vertex adds a closing edge, skipped below
// three vertices, and the result load, which waits for a free output
// register. One vertex is worked at a time.
// rst_n is synchronous; in_stall is high during reset and in the cycle after.
// A finished result waits in the output register while the next vertex is
// taken; a new result waits only while that register is still stalled.
module polygon_perimeter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [pp_pkg::COORD_W-1:0]  in_x_coord,
  input  logic signed [pp_pkg::COORD_W-1:0]  in_y_coord,
  input  logic                               in_last_vertex,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pp_pkg::SUM_W-1:0]           out_perimeter,
  output logic [1:0]                         out_status
);

  pp_pkg::pp_cmd_t  cmd;
  pp_pkg::pp_stat_t stat;

  pp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  pp_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_x_coord     (in_x_coord),
    .in_y_coord     (in_y_coord),
    .in_last_vertex (in_last_vertex),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_perimeter  (out_perimeter),
    .out_status     (out_status)
  );

  // A result is loaded only into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> stat.out_free)
    else $error("result loaded over an untaken result");

  // The root unit is started only when idle
  a_root_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.root_start |-> stat.root_done)
    else $error("square root restarted while busy");

  // A loaded result shows on the output in the next cycle
  a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid)
    else $error("loaded result not presented");

  // No vertex is taken while a result is being loaded
  a_no_take_on_emit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !cmd.capture)
    else $error("vertex taken during result load");

endmodule
